// File: src/aac_pkg.sv
// Shared types and constants of the annealing acceptance controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package aac_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int COST_W     = 32;
   localparam int TEMP_W     = 32;
   localparam int CF_W       = 16;
   localparam int RAND_W     = 16;
   localparam int PROB_W     = 16;
   localparam int FRAC_W     = 16;
   localparam int SAT_SHIFT  = 4;
   localparam int QUO_W      = FRAC_W + SAT_SHIFT;

   localparam logic [TEMP_W-1:0] MAX_TEMP_RST = 32'd6553600;
   localparam logic [TEMP_W-1:0] MIN_TEMP_RST = 32'd66;
   localparam logic [CF_W-1:0]   COOLING_RST  = 16'd64881;

   typedef enum logic [1:0] {
      CSR_MAX_TEMP,
      CSR_MIN_TEMP,
      CSR_COOLING
   } csr_idx_type;

   typedef struct packed {
      logic [TEMP_W-1:0] max_temp;
      logic [TEMP_W-1:0] min_temp;
      logic [CF_W-1:0]   cooling_factor;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [COST_W-1:0] dividend;
      logic [TEMP_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: src/aac_req_if.sv
// Input item channel of the annealing controller: valid/ready plus payload.
// Depends on aac_pkg for field widths.
`default_nettype none

interface aac_req_if;
   import aac_pkg::*;

   logic              valid;
   logic              ready;
   logic              func;
   logic signed [COST_W-1:0] cost;
   logic [RAND_W-1:0] rand_uniform;

   modport source (output valid, func, cost, rand_uniform, input ready);
   modport sink   (input valid, func, cost, rand_uniform, output ready);
endinterface

`default_nettype wire

// File: src/aac_rsp_if.sv
// Result item channel of the annealing controller: valid/ready plus payload.
// Depends on aac_pkg for field widths.
`default_nettype none

interface aac_rsp_if;
   import aac_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic                     new_best;
   logic signed [COST_W-1:0] best_cost;
   logic signed [COST_W-1:0] current_cost_out;
   logic [TEMP_W-1:0]        temperature_out;
   logic                     done_res;

   modport source (output valid, accepted, new_best, best_cost, current_cost_out,
                   temperature_out, done_res, input ready);
   modport sink   (input valid, accepted, new_best, best_cost, current_cost_out,
                   temperature_out, done_res, output ready);
endinterface

`default_nettype wire

// File: src/aac_csr.sv
// APB-style register file: max_temp, min_temp, cooling_factor.
// Depends on aac_pkg.
`default_nettype none

module aac_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [aac_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready,
   output aac_pkg::cfg_type                     cfg
);
   import aac_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_idx_type idx;
   logic        wr_en;

   assign idx    = csr_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_MAX_TEMP: cfg_in.max_temp       = pwdata;
            CSR_MIN_TEMP: cfg_in.min_temp       = pwdata;
            CSR_COOLING:  cfg_in.cooling_factor = pwdata[CF_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_MAX_TEMP: prdata = cfg_ff.max_temp;
         CSR_MIN_TEMP: prdata = cfg_ff.min_temp;
         CSR_COOLING:  prdata = {{(32-CF_W){1'b0}}, cfg_ff.cooling_factor};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_temp       <= MAX_TEMP_RST;
         cfg_ff.min_temp       <= MIN_TEMP_RST;
         cfg_ff.cooling_factor <= COOLING_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: src/aac_div.sv
// Restoring divider, one quotient bit per cycle: (dividend << 16) / divisor,
// valid only when the quotient is below 2^20. Depends on aac_pkg.
`default_nettype none

module aac_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire aac_pkg::div_req_type req,
   output aac_pkg::div_rsp_type      rsp
);
   import aac_pkg::*;

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [TEMP_W-1:0] rem_ff, rem_in;
   logic [TEMP_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W-1:0]  shin_ff, shin_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [TEMP_W:0]   shifted;
   logic [TEMP_W+1:0] diff;
   logic              fits;

   assign shifted = {rem_ff, shin_ff[QUO_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign fits    = ~diff[TEMP_W+1];

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      shin_in = shin_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = {{SAT_SHIFT{1'b0}}, req.dividend[COST_W-1:SAT_SHIFT]};
         shin_in = {req.dividend[SAT_SHIFT-1:0], {FRAC_W{1'b0}}};
         dvs_in  = req.divisor;
         quo_in  = '0;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[TEMP_W-1:0] : shifted[TEMP_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         shin_in = {shin_ff[QUO_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      shin_ff <= shin_in;
      quo_ff  <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a running division");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.start)
      else $error("divider started while busy");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !$past(req.start) |-> rem_ff < dvs_ff)
      else $error("partial remainder out of range");

endmodule

`default_nettype wire

// File: src/annealing_acceptance_controller_top.sv
// Simulated-annealing acceptance controller: Metropolis test, geometric cooling.
// Depends on aac_pkg, aac_req_if, aac_rsp_if, aac_csr and aac_div.
//
//   channel   dir  handshake        payload
//   req       in   valid/ready      func, cost, rand_uniform
//   rsp       out  valid/ready      accepted, new_best, best_cost,
//                                   current_cost_out, temperature_out, done_res
//   apb       in   psel/penable     max_temp, min_temp, cooling_factor
//
// A start item or an ignored candidate goes from check straight to finish.
// A candidate with a positive cost step below sixteen temperatures runs the
// 20-step divider, then index, lookup and decide; other candidates skip these.
// One item at a time; ready is high only in idle. A waiting result does not
// block the next accept, only the next result. Reset is synchronous.
`default_nettype none

module annealing_acceptance_controller_top #(
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   aac_req_if.sink                             req,
   aac_rsp_if.source                           rsp,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [aac_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready
);
   import aac_pkg::*;

   localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
   localparam int PROD_W = QUO_W + IDX_W + 1;
   localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(EXP_TABLE_DEPTH);

   // exp(-f), f in Q16.16 up to 1.0, result Q0.32; truncated Taylor terms
   function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
      logic [63:0] sum;
      logic [63:0] term;
      sum  = 64'd1 << 32;
      term = 64'd1 << 32;
      term = (term * f) / 64'd65536;  sum = sum - term;
      term = (term * f) / 64'd131072; sum = sum + term;
      term = (term * f) / 64'd196608; sum = sum - term;
      term = (term * f) / 64'd262144; sum = sum + term;
      term = (term * f) / 64'd327680; sum = sum - term;
      term = (term * f) / 64'd393216; sum = sum + term;
      term = (term * f) / 64'd458752; sum = sum - term;
      term = (term * f) / 64'd524288; sum = sum + term;
      term = (term * f) / 64'd589824; sum = sum - term;
      term = (term * f) / 64'd655360; sum = sum + term;
      term = (term * f) / 64'd720896; sum = sum - term;
      term = (term * f) / 64'd786432; sum = sum + term;
      term = (term * f) / 64'd851968; sum = sum - term;
      term = (term * f) / 64'd917504; sum = sum + term;
      return sum;
   endfunction

   function automatic logic [PROB_W-1:0] exp_entry(input int unsigned i);
      logic [63:0] e1;
      logic [63:0] y;
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] v;
      e1 = exp_neg_frac(64'd65536);
      y  = (64'(i) << 20) / EXP_TABLE_DEPTH;
      n  = y >> 16;
      r  = exp_neg_frac(y & 64'hFFFF);
      for (int j = 0; j < 16; j++) begin
         if (64'(j) < n) r = (r * e1) >> 32;
      end
      v = (r + 64'd32768) >> 16;
      if (v > 64'd65535) v = 64'd65535;
      return v[PROB_W-1:0];
   endfunction

   logic [PROB_W-1:0] exp_tab [EXP_TABLE_DEPTH];

   for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
      assign exp_tab[g] = exp_entry(g);
   end

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_SAT, ST_DIV, ST_INDEX, ST_LOOKUP, ST_DECIDE, ST_COOL, ST_FINISH
   } state_type;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   aac_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg)
   );

   aac_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   state_type                state_ff, state_in;
   logic                     func_ff, func_in;
   logic signed [COST_W-1:0] cost_ff, cost_in;
   logic [RAND_W-1:0]        rand_ff, rand_in;
   logic signed [COST_W:0]   delta_ff, delta_in;
   logic [QUO_W-1:0]         x_ff, x_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [PROB_W-1:0]        entry_ff, entry_in;
   logic                     acc_ff, acc_in;
   logic                     nb_ff, nb_in;
   logic                     eval_ff, eval_in;
   logic signed [COST_W-1:0] cur_ff, cur_in;
   logic signed [COST_W-1:0] best_ff, best_in;
   logic [TEMP_W-1:0]        temp_ff, temp_in;
   logic                     running_ff, running_in;
   logic                     ovalid_ff, ovalid_in;
   logic                     oacc_ff, oacc_in;
   logic                     onb_ff, onb_in;
   logic signed [COST_W-1:0] obest_ff, obest_in;
   logic signed [COST_W-1:0] ocur_ff, ocur_in;
   logic [TEMP_W-1:0]        otemp_ff, otemp_in;
   logic                     odone_ff, odone_in;

   logic                     hot;
   logic                     pos_delta;
   logic                     sat;
   logic [PROD_W-1:0]        idx_prod;
   logic [TEMP_W+CF_W-1:0]   cool_prod;
   logic signed [COST_W-1:0] cur_next;
   logic                     out_free;

   assign hot       = temp_ff > cfg.min_temp;
   assign pos_delta = !delta_ff[COST_W] && (delta_ff != '0);
   assign sat       = {{SAT_SHIFT{1'b0}}, delta_ff[COST_W-1:0]} >= {temp_ff, {SAT_SHIFT{1'b0}}};
   assign idx_prod  = PROD_W'(x_ff) * PROD_W'(DEPTH_C);
   assign cool_prod = (TEMP_W+CF_W)'(temp_ff) * (TEMP_W+CF_W)'(cfg.cooling_factor);
   assign cur_next  = acc_ff ? cost_ff : cur_ff;
   assign out_free  = !ovalid_ff || rsp.ready;

   assign req.ready        = (state_ff == ST_IDLE);
   assign div_req.start    = (state_ff == ST_SAT) && pos_delta && !sat;
   assign div_req.dividend = delta_ff[COST_W-1:0];
   assign div_req.divisor  = temp_ff;

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      cost_in    = cost_ff;
      rand_in    = rand_ff;
      delta_in   = delta_ff;
      x_in       = x_ff;
      idx_in     = idx_ff;
      entry_in   = entry_ff;
      acc_in     = acc_ff;
      nb_in      = nb_ff;
      eval_in    = eval_ff;
      cur_in     = cur_ff;
      best_in    = best_ff;
      temp_in    = temp_ff;
      running_in = running_ff;
      ovalid_in  = ovalid_ff && !rsp.ready;
      oacc_in    = oacc_ff;
      onb_in     = onb_ff;
      obest_in   = obest_ff;
      ocur_in    = ocur_ff;
      otemp_in   = otemp_ff;
      odone_in   = odone_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               func_in  = req.func;
               cost_in  = req.cost;
               rand_in  = req.rand_uniform;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            acc_in   = 1'b0;
            nb_in    = 1'b0;
            eval_in  = 1'b1;
            delta_in = (COST_W+1)'(cost_ff) - (COST_W+1)'(cur_ff);
            if (!func_ff) begin
               cur_in   = cost_ff;
               best_in  = cost_ff;
               temp_in  = cfg.max_temp;
               acc_in   = 1'b1;
               nb_in    = 1'b1;
               state_in = ST_FINISH;
            end else if (!(running_ff && hot)) begin
               eval_in  = 1'b0;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (!pos_delta) begin
               acc_in   = 1'b1;
               state_in = ST_COOL;
            end else if (sat) begin
               state_in = ST_COOL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               x_in     = div_rsp.quotient;
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            idx_in   = idx_prod[QUO_W +: IDX_W];
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            entry_in = exp_tab[idx_ff];
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            acc_in   = rand_ff < entry_ff;
            state_in = ST_COOL;
         end
         ST_COOL: begin
            cur_in = cur_next;
            if (cur_next < best_ff) begin
               best_in = cur_next;
               nb_in   = 1'b1;
            end
            temp_in  = cool_prod[FRAC_W +: TEMP_W];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               running_in = eval_ff && hot;
               ovalid_in  = 1'b1;
               oacc_in    = acc_ff;
               onb_in     = nb_ff;
               obest_in   = best_ff;
               ocur_in    = cur_ff;
               otemp_in   = temp_ff;
               odone_in   = !(eval_ff && hot);
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cur_ff     <= '0;
         best_ff    <= '0;
         temp_ff    <= '0;
         running_ff <= 1'b0;
         ovalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cur_ff     <= cur_in;
         best_ff    <= best_in;
         temp_ff    <= temp_in;
         running_ff <= running_in;
         ovalid_ff  <= ovalid_in;
      end
      func_ff  <= func_in;
      cost_ff  <= cost_in;
      rand_ff  <= rand_in;
      delta_ff <= delta_in;
      x_ff     <= x_in;
      idx_ff   <= idx_in;
      entry_ff <= entry_in;
      acc_ff   <= acc_in;
      nb_ff    <= nb_in;
      eval_ff  <= eval_in;
      oacc_ff  <= oacc_in;
      onb_ff   <= onb_in;
      obest_ff <= obest_in;
      ocur_ff  <= ocur_in;
      otemp_ff <= otemp_in;
      odone_ff <= odone_in;
   end

   assign rsp.valid            = ovalid_ff;
   assign rsp.accepted         = oacc_ff;
   assign rsp.new_best         = onb_ff;
   assign rsp.best_cost        = obest_ff;
   assign rsp.current_cost_out = ocur_ff;
   assign rsp.temperature_out  = otemp_ff;
   assign rsp.done_res         = odone_ff;

   a_best_le_cur: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> best_ff <= cur_ff)
      else $error("best cost above current cost");
   a_cool_no_rise: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COOL |=> temp_ff <= $past(temp_ff))
      else $error("temperature rose on cooling");
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(ovalid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result loaded outside the finish step");

endmodule

`default_nettype wire

// File: tb/anneal_tb_pkg.sv
// Testbench-side codes for the annealing controller bench.
// No dependencies; imported by the outcome checker and the testbench top.
`default_nettype none

package anneal_tb_pkg;

   typedef enum logic {
      OP_START     = 1'b0,
      OP_CANDIDATE = 1'b1
   } anneal_op_type;

   localparam int UNUSED_CSR = 3;

endpackage

`default_nettype wire

// File: tb/anneal_outcome_checker.sv
// Watches the item, result and register ports of the annealing controller,
// predicts every result with a Metropolis/cooling model and compares them.
// Depends on aac_pkg, aac_req_if, aac_rsp_if and anneal_tb_pkg.
`default_nettype none

module anneal_outcome_checker #(
   parameter int DEPTH = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   aac_req_if                                  req,
   aac_rsp_if                                  rsp,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic                           pready,
   input  wire logic [aac_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output int                                  mismatches,
   output int                                  outstanding
);
   import aac_pkg::*;
   import anneal_tb_pkg::*;

   typedef struct packed {
      logic                     accepted;
      logic                     new_best;
      logic signed [COST_W-1:0] best_cost;
      logic signed [COST_W-1:0] current_cost;
      logic [TEMP_W-1:0]        temperature;
      logic                     done;
   } outcome_type;

   outcome_type              expected_outcomes[$];
   logic [PROB_W-1:0]        exp_lut[DEPTH];
   cfg_type                  cfg;
   logic signed [COST_W-1:0] cur_cost;
   logic signed [COST_W-1:0] best_cost;
   logic [TEMP_W-1:0]        temp;
   logic                     running;
   int                       results_seen;

   // exp(-f), f in Q16.16 up to 1.0, Q0.32 result from a truncated series
   function automatic bit [63:0] exp_neg_q32(input bit [63:0] f);
      bit [63:0] sum;
      bit [63:0] term;
      sum  = 64'h1_0000_0000;
      term = 64'h1_0000_0000;
      for (bit [63:0] k = 1; k <= 14; k++) begin
         term = (term * f) / (k << 16);
         if (k[0])
            sum -= term;
         else
            sum += term;
      end
      return sum;
   endfunction

   function automatic outcome_type metropolis_step(input anneal_op_type op,
                                                   input logic signed [COST_W-1:0] c,
                                                   input logic [RAND_W-1:0] rnd);
      outcome_type o;
      longint      delta;
      bit [63:0]   quot;
      bit [63:0]   idx;
      o = '0;
      if (op == OP_START) begin
         cur_cost   = c;
         best_cost  = c;
         temp       = cfg.max_temp;
         running    = temp > cfg.min_temp;
         o.accepted = 1'b1;
         o.new_best = 1'b1;
      end else if (running && temp > cfg.min_temp) begin
         delta = longint'(c) - longint'(cur_cost);
         if (delta <= 0) begin
            o.accepted = 1'b1;
         end else begin
            quot = (64'(unsigned'(delta)) << 16) / 64'(temp);
            if (quot < (64'd16 << 16)) begin
               idx = (quot * 64'(DEPTH)) >> 20;
               if (idx < 64'(DEPTH) && rnd < exp_lut[idx])
                  o.accepted = 1'b1;
            end
         end
         if (o.accepted)
            cur_cost = c;
         if (cur_cost < best_cost) begin
            best_cost  = cur_cost;
            o.new_best = 1'b1;
         end
         temp    = 32'((64'(temp) * 64'(cfg.cooling_factor)) >> 16);
         running = temp > cfg.min_temp;
      end else begin
         running = 1'b0;
      end
      o.best_cost    = best_cost;
      o.current_cost = cur_cost;
      o.temperature  = temp;
      o.done         = !running;
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t, result %0d: %s", $time, results_seen, msg);
      mismatches++;
   endtask

   initial begin : build_lut
      bit [63:0] e1;
      bit [63:0] y;
      bit [63:0] r;
      bit [63:0] v;
      mismatches  = 0;
      outstanding = 0;
      e1 = exp_neg_q32(64'h1_0000);
      for (int i = 0; i < DEPTH; i++) begin
         y = (64'(unsigned'(i)) << 20) / 64'(DEPTH);
         r = exp_neg_q32(y & 64'hFFFF);
         repeat (y >> 16) r = (r * e1) >> 32;
         v = (r + 64'h8000) >> 16;
         exp_lut[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
   end

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         cfg.max_temp       = MAX_TEMP_RST;
         cfg.min_temp       = MIN_TEMP_RST;
         cfg.cooling_factor = COOLING_RST;
         cur_cost           = '0;
         best_cost          = '0;
         temp               = '0;
         running            = 1'b0;
         results_seen       = 0;
         expected_outcomes.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp.accepted !== want.accepted)
                  report_mismatch($sformatf("accepted got %b want %b",
                                            rsp.accepted, want.accepted));
               if (rsp.new_best !== want.new_best)
                  report_mismatch($sformatf("new_best got %b want %b",
                                            rsp.new_best, want.new_best));
               if (rsp.best_cost !== want.best_cost)
                  report_mismatch($sformatf("best_cost got %h want %h",
                                            rsp.best_cost, want.best_cost));
               if (rsp.current_cost_out !== want.current_cost)
                  report_mismatch($sformatf("current_cost_out got %h want %h",
                                            rsp.current_cost_out, want.current_cost));
               if (rsp.temperature_out !== want.temperature)
                  report_mismatch($sformatf("temperature_out got %h want %h",
                                            rsp.temperature_out, want.temperature));
               if (rsp.done_res !== want.done)
                  report_mismatch($sformatf("done_res got %b want %b",
                                            rsp.done_res, want.done));
            end
            results_seen++;
         end
         if (req.valid && req.ready)
            expected_outcomes.push_back(metropolis_step(anneal_op_type'(req.func), req.cost,
                                                        req.rand_uniform));
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               CSR_MAX_TEMP: cfg.max_temp       = pwdata;
               CSR_MIN_TEMP: cfg.min_temp       = pwdata;
               CSR_COOLING:  cfg.cooling_factor = pwdata[CF_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_outcomes.size();
   end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Testbench top for the annealing acceptance controller: clock, reset,
// directed and random item streams, register phases and the verdict.
// Depends on aac_pkg, the channel interfaces, anneal_tb_pkg and the checker.
`default_nettype none

module testbench;
   import aac_pkg::*;
   import anneal_tb_pkg::*;

   localparam int EXP_DEPTH = 256;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;
   int                    mismatches;
   int                    outstanding;
   int                    idle_pct;
   int                    stall_pct;
   int                    rsp_hold;

   aac_req_if req_ch();
   aac_rsp_if rsp_ch();

   always #5 clock = ~clock;

   annealing_acceptance_controller_top #(
      .EXP_TABLE_DEPTH(EXP_DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   anneal_outcome_checker #(
      .DEPTH(EXP_DEPTH)
   ) u_outcome_chk (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // result side: ready drops in random stall bursts
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_hold = $urandom_range(1, 6) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // all tasks are entered and left at a falling edge
   task automatic send_item(input anneal_op_type op, input logic signed [COST_W-1:0] c,
                            input logic [RAND_W-1:0] rnd);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= op;
      req_ch.cost         <= c;
      req_ch.rand_uniform <= rnd;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_schedule(input logic [31:0] max_t, input logic [31:0] min_t,
                                   input logic [31:0] cf_word);
      write_csr(CSR_ADDR_W'(4 * CSR_MAX_TEMP), max_t);
      write_csr(CSR_ADDR_W'(4 * CSR_MIN_TEMP), min_t);
      write_csr(CSR_ADDR_W'(4 * CSR_COOLING), cf_word);
   endtask

   initial begin : stimulus
      int                       random_items;
      int                       run_len;
      int                       pick;
      logic [31:0]              max_t;
      logic [31:0]              min_t;
      logic [CF_W-1:0]          cf;
      logic signed [COST_W-1:0] base;
      logic signed [COST_W-1:0] cost;
      logic [RAND_W-1:0]        rnd;

      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.func         = OP_START;
      req_ch.cost         = '0;
      req_ch.rand_uniform = '0;
      rsp_ch.ready        = 1'b0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      rsp_hold            = 0;
      idle_pct            = 25;
      stall_pct           = 25;
      random_items        = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset schedule; candidate before any start is ignored
      send_item(OP_CANDIDATE, 32'sh1234_5678, 16'h0000);
      send_item(OP_START, 32'sh0000_0000, 16'hFFFF);
      send_item(OP_CANDIDATE, -32'sh0001_0000, 16'hFFFF);
      send_item(OP_CANDIDATE, -32'sh0001_0000, 16'hFFFF);
      send_item(OP_CANDIDATE, 32'sh0032_0000, 16'h0000);
      send_item(OP_CANDIDATE, 32'sh0064_0000, 16'hFFFF);
      send_item(OP_CANDIDATE, 32'sh7FFF_FFFF, 16'h0000);
      send_item(OP_CANDIDATE, 32'sh8000_0000, 16'hFFFF);

      // hottest start, slowest cooling: full-range cost step lands at x = 1.0
      drain();
      program_schedule(32'hFFFF_FFFF, 32'h0, 32'h0000_FFFF);
      send_item(OP_START, 32'sh8000_0000, 16'h0000);
      send_item(OP_CANDIDATE, 32'sh7FFF_FFFF, 16'h0000);
      send_item(OP_CANDIDATE, 32'sh8000_0000, 16'hFFFF);
      send_item(OP_CANDIDATE, 32'sh7FFF_FFFF, 16'hFFFF);
      send_item(OP_START, 32'sh7FFF_FFFF, 16'h1234);

      // smallest temperature, zero cooling: one candidate ends the run
      drain();
      program_schedule(32'h1, 32'h0, 32'h0);
      send_item(OP_START, 32'sh0, 16'h0000);
      send_item(OP_CANDIDATE, 32'sh0001_0000, 16'h0000);
      send_item(OP_CANDIDATE, -32'sh5, 16'h0000);

      // stop temperature above start temperature
      drain();
      program_schedule(32'd100, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_START, 32'sh0000_1000, 16'h0000);
      send_item(OP_CANDIDATE, -32'sh0000_1000, 16'h0000);

      // stop temperature raised mid-run, then lowered again
      drain();
      program_schedule(MAX_TEMP_RST, MIN_TEMP_RST, {16'hA5A5, COOLING_RST});
      write_csr(CSR_ADDR_W'(4 * UNUSED_CSR), 32'hFFFF_FFFF);
      send_item(OP_START, 32'sh0000_03E8, 16'h0000);
      send_item(OP_CANDIDATE, 32'sh0000_0384, 16'h8000);
      drain();
      write_csr(CSR_ADDR_W'(4 * CSR_MIN_TEMP), 32'hFFFF_FFFF);
      send_item(OP_CANDIDATE, 32'sh0000_0100, 16'h0000);
      drain();
      write_csr(CSR_ADDR_W'(4 * CSR_MIN_TEMP), MIN_TEMP_RST);
      send_item(OP_CANDIDATE, 32'sh0000_0100, 16'h0000);

      while (random_items < 1600) begin
         drain();
         if (random_items >= 1360) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = 25 * $urandom_range(0, 2);
            stall_pct = 25 * $urandom_range(0, 2);
         end
         case ($urandom_range(0, 3))
            0:       max_t = 32'hFFFF_FFFF;
            1:       max_t = $urandom_range(1, 32'h0040_0000);
            2:       max_t = MAX_TEMP_RST;
            default: max_t = $urandom;
         endcase
         if (max_t == 0)
            max_t = 1;
         run_len = $urandom_range(30, 150);
         case ($urandom_range(0, 7))
            0:       min_t = 0;
            1:       min_t = max_t >> $urandom_range(1, 16);
            2: begin
               min_t   = $urandom;
               run_len = 4;
            end
            default: min_t = $urandom_range(0, 1000);
         endcase
         case ($urandom_range(0, 9))
            0:       cf = 16'hFFFF;
            1: begin
               cf      = 16'h0000;
               run_len = 4;
            end
            2:       cf = 16'($urandom);
            default: cf = 16'($urandom_range(58000, 65500));
         endcase
         program_schedule(max_t, min_t, {16'($urandom), cf});

         base = $signed($urandom) >>> $urandom_range(0, 16);
         send_item(OP_START, base, 16'($urandom));
         random_items++;
         repeat (run_len) begin
            pick = $urandom_range(0, 9);
            rnd  = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               base = $signed($urandom) >>> $urandom_range(0, 16);
               send_item(OP_START, base, rnd);
            end else if (pick < 12) begin
               send_item(OP_CANDIDATE, $signed($urandom), rnd);
            end else begin
               cost = base + ($signed($urandom) >>> $urandom_range(0, 31));
               send_item(OP_CANDIDATE, cost, rnd);
            end
            random_items++;
         end
      end
      drain();

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
src/aac_pkg.sv
src/aac_req_if.sv
src/aac_rsp_if.sv
src/aac_csr.sv
src/aac_div.sv
src/annealing_acceptance_controller_top.sv
tb/anneal_tb_pkg.sv
tb/anneal_outcome_checker.sv
tb/testbench.sv
